[rtl/sci_pkg.sv]
// Shared types and constants for the snapshot coefficient interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package sci_pkg;

    // Fixed field widths of the item and result payloads.
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 8;
    localparam int COEF_W  = 48;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int DEG_W   = 5;
    localparam int IN_W    = TIME_W + 2 * IDX_W + 4 * COEF_W;
    localparam int OUT_W   = 2 * COEF_W;

    // Width of the low half of a coefficient difference, and of a multiplier operand.
    localparam int LO_W    = 25;
    localparam int OPND_W  = 26;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_LOAD   = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK      = 3'd0,
        STS_NOSNAP  = 3'd1,
        STS_REJECT  = 3'd2,
        STS_FULL    = 3'd3,
        STS_DEGREE  = 3'd4,
        STS_SAT     = 3'd5
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_TBL_CLEAR,
        OP_ROW_START,
        OP_CLR_STEP,
        OP_LOAD,
        OP_QSTART,
        OP_SCAN,
        OP_SEL,
        OP_PICK_S1,
        OP_CAP_T0,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_WEIGHT,
        OP_MEM1,
        OP_CAP_X0,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res_status;
        logic    res_interp;
    } ctl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  count_zero;
        logic  count_full;
        logic  load_bad;
        logic  deg_out;
        logic  m_gt_n;
        logic  clr_done;
        logic  scan_done;
        logic  div_done;
        logic  mul_done;
        logic  out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

[rtl/sci_ctrl.sv]
// Controller state machine of the snapshot coefficient interpolator.
// Depends on sci_pkg; drives the datapath through ctl_cmd_t only.
`default_nettype none
module sci_ctrl
    import sci_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t st,
    output ctl_cmd_t      cmd
);

    typedef enum logic [15:0] {
        ST_INIT   = 16'h0001,
        ST_IDLE   = 16'h0002,
        ST_DECODE = 16'h0004,
        ST_ROWCLR = 16'h0008,
        ST_SCAN   = 16'h0010,
        ST_SEL    = 16'h0020,
        ST_T0     = 16'h0040,
        ST_T1     = 16'h0080,
        ST_DIVS   = 16'h0100,
        ST_DIV    = 16'h0200,
        ST_WGT    = 16'h0400,
        ST_M0     = 16'h0800,
        ST_M1     = 16'h1000,
        ST_M2     = 16'h2000,
        ST_MUL    = 16'h4000,
        ST_RESULT = 16'h8000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    interp_reg, interp_next;

    // State and result code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            code_reg   <= STS_OK;
            interp_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            interp_reg <= interp_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        interp_next    = interp_reg;
        cmd.op         = OP_NONE;
        cmd.res_status = code_reg;
        cmd.res_interp = interp_reg;
        s_ready        = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.op = OP_CLR_STEP;
                if (st.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                interp_next = 1'b0;
                code_next   = STS_OK;
                state_next  = ST_RESULT;
                unique case (st.func)
                    FUNC_CLEAR:
                        cmd.op = OP_TBL_CLEAR;
                    FUNC_APPEND:
                    begin
                        if (st.count_full)
                            code_next = STS_FULL;
                        else
                        begin
                            cmd.op     = OP_ROW_START;
                            state_next = ST_ROWCLR;
                        end
                    end
                    FUNC_LOAD:
                    begin
                        priority if (st.count_zero)
                            code_next = STS_NOSNAP;
                        else if (st.load_bad)
                            code_next = STS_REJECT;
                        else
                            cmd.op = OP_LOAD;
                    end
                    FUNC_QUERY:
                    begin
                        priority if (st.count_zero)
                            code_next = STS_NOSNAP;
                        else if (st.deg_out)
                            code_next = STS_DEGREE;
                        else if (!st.m_gt_n)
                        begin
                            cmd.op      = OP_QSTART;
                            interp_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end
                    default:
                        state_next = ST_RESULT;
                endcase
            end
            ST_ROWCLR:
            begin
                cmd.op = OP_CLR_STEP;
                if (st.clr_done)
                    state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (st.scan_done)
                    state_next = ST_SEL;
            end
            ST_SEL:
            begin
                cmd.op     = OP_SEL;
                state_next = ST_T0;
            end
            ST_T0:
            begin
                cmd.op     = OP_PICK_S1;
                state_next = ST_T1;
            end
            ST_T1:
            begin
                cmd.op     = OP_CAP_T0;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (st.div_done)
                    state_next = ST_WGT;
                else
                    cmd.op = OP_DIV_STEP;
            end
            ST_WGT:
            begin
                cmd.op     = OP_WEIGHT;
                state_next = ST_M0;
            end
            ST_M0:
            begin
                cmd.op     = OP_MEM1;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.op     = OP_CAP_X0;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op     = OP_MUL_INIT;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (st.mul_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/sci_datapath.sv]
// Datapath of the snapshot coefficient interpolator: tables, bracket scan,
// weight divider, multiply-accumulate and result register. Depends on sci_pkg.
`default_nettype none
module sci_datapath
    import sci_pkg::*;
#(
    parameter int MAX_SNAPSHOTS    = 16,
    parameter int DEGREE_CAP       = 31,
    parameter int WEIGHT_FRAC_BITS = 20
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctl_cmd_t                 cmd,
    output dp_stat_t                      st,
    input  wire func_t                    in_func,
    input  wire logic [TIME_W-1:0]        in_time,
    input  wire logic [IDX_W-1:0]         in_degree,
    input  wire logic [IDX_W-1:0]         in_order,
    input  wire logic signed [COEF_W-1:0] in_load_cos,
    input  wire logic signed [COEF_W-1:0] in_load_sin,
    input  wire logic signed [COEF_W-1:0] in_base_cos,
    input  wire logic signed [COEF_W-1:0] in_base_sin,
    input  wire logic                     cfg_we,
    input  wire logic [DEG_W-1:0]         cfg_wdata,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output status_t                       out_status,
    output logic signed [COEF_W-1:0]      out_cos,
    output logic signed [COEF_W-1:0]      out_sin
);

    localparam int F      = WEIGHT_FRAC_BITS;
    localparam int TRI    = (DEGREE_CAP + 1) * (DEGREE_CAP + 2) / 2;
    localparam int DEPTH  = MAX_SNAPSHOTS * TRI;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = $clog2(TRI);
    localparam int SW     = $clog2(MAX_SNAPSHOTS);
    localparam int CW     = $clog2(MAX_SNAPSHOTS + 1);
    localparam int QW     = TIME_W + F;
    localparam int WW     = F + 4;
    localparam int PW     = WW + OPND_W;
    localparam int ACC_W  = F + 56;
    localparam int RW     = ACC_W - F;
    localparam int MW     = 2 * COEF_W + 1;
    localparam int DW     = COEF_W + 1;
    localparam int DCNT_W = $clog2(QW + 1);

    // Start of a snapshot's row in the coefficient memory.
    function automatic logic [AW-1:0] row_base(input logic [SW-1:0] s);
        return AW'(s) * AW'(TRI);
    endfunction

    // Drop the fraction bits and saturate to 48 bits; bit 48 flags a clip.
    function automatic logic [COEF_W:0] sat_out(input logic signed [ACC_W-1:0] a);
        logic [RW-1:0] r;
        r = a[ACC_W-1:F];
        if (r[RW-1:COEF_W-1] == {(RW-COEF_W+1){r[COEF_W-1]}})
            return {1'b0, r[COEF_W-1:0]};
        else if (r[RW-1])
            return {1'b1, 1'b1, {(COEF_W-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(COEF_W-1){1'b1}}};
    endfunction

    // Captured item.
    func_t                     func_reg;
    logic [TIME_W-1:0]         tq_reg;
    logic [IDX_W-1:0]          n_reg, m_reg;
    logic signed [COEF_W-1:0]  lcos_reg, lsin_reg, bcos_reg, bsin_reg;

    // Control state.
    logic [DEG_W-1:0]          degree_reg;
    logic [CW-1:0]             count_reg;
    logic [AW-1:0]             clr_addr_reg, clr_end_reg;
    logic                      clr_row_reg;
    logic [SW-1:0]             tidx_reg, rd_idx_reg;
    logic                      rd_v_reg;
    logic                      found_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;
    logic [2:0]                mul_cnt_reg;
    logic                      out_valid_reg;

    // Query payload.
    logic [TIME_W-1:0]         t_first_reg, t_last_reg, t0_reg, t_rd_reg;
    logic [SW-1:0]             found_idx_reg, s0_reg, s1_reg;
    logic [TIME_W-1:0]         d_reg, rem_reg;
    logic [QW-1:0]             q_reg;
    logic                      neg_reg, dzero_reg, presat_reg, satw_reg;
    logic signed [WW-1:0]      w1_reg;
    logic [AW-1:0]             maddr_reg;
    logic [MW-1:0]             mem_rd_reg;
    logic signed [COEF_W-1:0]  x0c_reg, x0s_reg;
    logic signed [DW-1:0]      dc_reg, ds_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [ACC_W-1:0]   accc_reg, accs_reg;
    status_t                   ost_reg;
    logic signed [COEF_W-1:0]  ocos_reg, osin_reg;

    logic [TIME_W-1:0]         tmem [MAX_SNAPSHOTS];
    logic [MW-1:0]             cmem [DEPTH];

    logic [IDX_W-1:0]          limit;
    logic [2*IDX_W-1:0]        nn;
    logic [TW-1:0]             tri_idx;
    logic [SW-1:0]             last, s1_sel, s0_sel;
    logic                      one;
    logic signed [TIME_W:0]    num, dt;
    logic [TIME_W-1:0]         a_mag, d_mag;
    logic [TIME_W:0]           rem2;
    logic                      ge;
    logic [WW-1:0]             qm, w_pos;
    logic signed [WW-1:0]      w_next;
    logic signed [COEF_W-1:0]  x1c, x1s;
    logic signed [DW-1:0]      bxc, bxs;
    logic signed [OPND_W-1:0]  opnd;
    logic signed [PW-1:0]      prod_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [COEF_W:0]           rc, rs;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [MW-1:0]             mem_wdata;

    // Decode of the captured item.
    always_comb
    begin
        limit   = (IDX_W'(degree_reg) < IDX_W'(DEGREE_CAP)) ? IDX_W'(degree_reg)
                                                          : IDX_W'(DEGREE_CAP);
        nn      = (2*IDX_W)'(n_reg) * ((2*IDX_W)'(n_reg) + 1'b1);
        tri_idx = TW'((nn >> 1) + (2*IDX_W)'(m_reg));
        last    = SW'(count_reg - 1'b1);
        one     = (count_reg == CW'(1));
    end

    // Bracket selection from the scan results.
    always_comb
    begin
        priority if (one)
            s1_sel = '0;
        else if (tq_reg <= t_first_reg)
            s1_sel = SW'(1);
        else if (tq_reg >= t_last_reg)
            s1_sel = last;
        else if (found_reg)
            s1_sel = found_idx_reg;
        else
            s1_sel = last;
        s0_sel = one ? '0 : SW'(s1_sel - 1'b1);
    end

    // Weight set-up, divider step and weight finish.
    always_comb
    begin
        num   = $signed({1'b0, tq_reg}) - $signed({1'b0, t0_reg});
        dt    = $signed({1'b0, t_rd_reg}) - $signed({1'b0, t0_reg});
        a_mag = num[TIME_W] ? TIME_W'(-num) : num[TIME_W-1:0];
        d_mag = dt[TIME_W] ? TIME_W'(-dt) : dt[TIME_W-1:0];
        rem2  = {rem_reg, q_reg[QW-1]};
        ge    = (rem2 >= {1'b0, d_reg});
        qm    = presat_reg ? (WW'(1) << (F + 3)) : {1'b0, q_reg[F+2:0]};
        w_pos = (qm >= (WW'(8) << F)) ? ((WW'(8) << F) - 1'b1) : qm;
        priority if (dzero_reg)
            w_next = '0;
        else if (neg_reg)
            w_next = $signed(WW'(0) - qm);
        else
            w_next = $signed(w_pos);
    end

    // Multiply-accumulate operands.
    always_comb
    begin
        x1c = mem_rd_reg[MW-1] ? $signed(mem_rd_reg[2*COEF_W-1:COEF_W]) : '0;
        x1s = mem_rd_reg[MW-1] ? $signed(mem_rd_reg[COEF_W-1:0]) : '0;
        bxc = DW'(bcos_reg) + DW'(x0c_reg);
        bxs = DW'(bsin_reg) + DW'(x0s_reg);
        unique case (mul_cnt_reg[1:0])
            2'd0:    opnd = $signed({1'b0, dc_reg[LO_W-1:0]});
            2'd1:    opnd = OPND_W'($signed(dc_reg[DW-1:LO_W]));
            2'd2:    opnd = $signed({1'b0, ds_reg[LO_W-1:0]});
            default: opnd = OPND_W'($signed(ds_reg[DW-1:LO_W]));
        endcase
        prod_next = w1_reg * opnd;
        prod_ext  = ACC_W'(prod_reg);
        rc        = sat_out(accc_reg);
        rs        = sat_out(accs_reg);
    end

    // Coefficient memory write port.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (cmd.op == OP_CLR_STEP)
            mem_we = 1'b1;
        else if (cmd.op == OP_LOAD)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_base(last) + AW'(tri_idx);
            mem_wdata = {1'b1, lcos_reg, lsin_reg};
        end
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cmem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= cmem[maddr_reg];
        if (cmd.op == OP_ROW_START)
            tmem[count_reg[SW-1:0]] <= tq_reg;
        t_rd_reg <= tmem[tidx_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg    <= DEG_W'(31);
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_end_reg   <= AW'(DEPTH - 1);
            clr_row_reg   <= 1'b0;
            tidx_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                degree_reg <= cfg_wdata;
            rd_v_reg   <= (cmd.op == OP_SCAN);
            rd_idx_reg <= tidx_reg;
            if (rd_v_reg && rd_idx_reg != '0 && !found_reg && t_rd_reg > tq_reg)
                found_reg <= 1'b1;
            // A new result replaces the one leaving in the same cycle.
            if (cmd.op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                OP_TBL_CLEAR:
                    count_reg <= '0;
                OP_ROW_START:
                begin
                    clr_addr_reg <= row_base(count_reg[SW-1:0]);
                    clr_end_reg  <= row_base(count_reg[SW-1:0]) + AW'(TRI - 1);
                    clr_row_reg  <= 1'b1;
                end
                OP_CLR_STEP:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == clr_end_reg && clr_row_reg)
                        count_reg <= count_reg + 1'b1;
                end
                OP_QSTART:
                begin
                    tidx_reg  <= '0;
                    found_reg <= 1'b0;
                end
                OP_SCAN:
                    if (tidx_reg != last)
                        tidx_reg <= tidx_reg + 1'b1;
                OP_SEL:
                    tidx_reg <= s0_sel;
                OP_PICK_S1:
                    tidx_reg <= s1_reg;
                OP_DIV_START:
                    div_cnt_reg <= DCNT_W'(QW);
                OP_DIV_STEP:
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                OP_MUL_INIT:
                    mul_cnt_reg <= '0;
                OP_MUL_STEP:
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                default:
                    count_reg <= count_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            if (rd_idx_reg == '0)
                t_first_reg <= t_rd_reg;
            if (rd_idx_reg == last)
                t_last_reg <= t_rd_reg;
            if (rd_idx_reg != '0 && !found_reg && t_rd_reg > tq_reg)
                found_idx_reg <= rd_idx_reg;
        end
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                func_reg <= in_func;
                tq_reg   <= in_time;
                n_reg    <= in_degree;
                m_reg    <= in_order;
                lcos_reg <= in_load_cos;
                lsin_reg <= in_load_sin;
                bcos_reg <= in_base_cos;
                bsin_reg <= in_base_sin;
            end
            OP_SEL:
            begin
                s0_reg <= s0_sel;
                s1_reg <= s1_sel;
            end
            OP_CAP_T0:
                t0_reg <= t_rd_reg;
            OP_DIV_START:
            begin
                d_reg      <= d_mag;
                rem_reg    <= '0;
                q_reg      <= {a_mag, {F{1'b0}}};
                neg_reg    <= num[TIME_W] ^ dt[TIME_W];
                dzero_reg  <= (dt == '0);
                presat_reg <= ({3'b000, a_mag} >= {d_mag, 3'b000});
            end
            OP_DIV_STEP:
            begin
                rem_reg <= ge ? TIME_W'(rem2 - {1'b0, d_reg}) : rem2[TIME_W-1:0];
                q_reg   <= {q_reg[QW-2:0], ge};
            end
            OP_WEIGHT:
            begin
                w1_reg    <= w_next;
                satw_reg  <= !dzero_reg && presat_reg;
                maddr_reg <= row_base(s0_reg) + AW'(tri_idx);
            end
            OP_MEM1:
                maddr_reg <= row_base(s1_reg) + AW'(tri_idx);
            OP_CAP_X0:
            begin
                x0c_reg <= mem_rd_reg[MW-1] ? $signed(mem_rd_reg[2*COEF_W-1:COEF_W]) : '0;
                x0s_reg <= mem_rd_reg[MW-1] ? $signed(mem_rd_reg[COEF_W-1:0]) : '0;
            end
            OP_MUL_INIT:
            begin
                dc_reg   <= DW'(x1c) - DW'(x0c_reg);
                ds_reg   <= DW'(x1s) - DW'(x0s_reg);
                accc_reg <= (ACC_W'(bxc) <<< F) + (ACC_W'(1) << (F - 1));
                accs_reg <= (ACC_W'(bxs) <<< F) + (ACC_W'(1) << (F - 1));
            end
            OP_MUL_STEP:
            begin
                if (mul_cnt_reg != 3'd4)
                    prod_reg <= prod_next;
                unique case (mul_cnt_reg)
                    3'd1:    accc_reg <= accc_reg + prod_ext;
                    3'd2:    accc_reg <= accc_reg + (prod_ext <<< LO_W);
                    3'd3:    accs_reg <= accs_reg + prod_ext;
                    3'd4:    accs_reg <= accs_reg + (prod_ext <<< LO_W);
                    default: accc_reg <= accc_reg;
                endcase
            end
            OP_RESULT:
            begin
                if (cmd.res_interp)
                begin
                    ost_reg  <= (satw_reg || rc[COEF_W] || rs[COEF_W]) ? STS_SAT : STS_OK;
                    ocos_reg <= $signed(rc[COEF_W-1:0]);
                    osin_reg <= $signed(rs[COEF_W-1:0]);
                end
                else
                begin
                    ost_reg  <= cmd.res_status;
                    ocos_reg <= bcos_reg;
                    osin_reg <= bsin_reg;
                end
            end
            default:
                tq_reg <= tq_reg;
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        st.func       = func_reg;
        st.count_zero = (count_reg == '0);
        st.count_full = (count_reg >= CW'(MAX_SNAPSHOTS));
        st.load_bad   = (m_reg > n_reg) || (n_reg > limit);
        st.deg_out    = (n_reg > limit);
        st.m_gt_n     = (m_reg > n_reg);
        st.clr_done   = (clr_addr_reg == clr_end_reg);
        st.scan_done  = rd_v_reg && (rd_idx_reg == last);
        st.div_done   = (div_cnt_reg == '0);
        st.mul_done   = (mul_cnt_reg == 3'd4);
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = ost_reg;
    assign out_cos    = ocos_reg;
    assign out_sin    = osin_reg;

endmodule
`default_nettype wire

[rtl/snapshot_coefficient_interpolator_unit.sv]
// Top level of the snapshot coefficient interpolator: stream ports, field
// packing, controller and datapath. Depends on sci_pkg, sci_ctrl, sci_datapath.
//
// One item is worked on at a time; a finished result waits in an output
// register while the next item is taken. Clear, load and rejected items pass
// through capture, decode and result only. An append clears the new snapshot's
// coefficient row of (DEGREE_CAP+1)*(DEGREE_CAP+2)/2 entries one entry a cycle.
// A query scans the snapshot times one per cycle, then runs a bit-serial
// divider for the weight (32 + WEIGHT_FRAC_BITS steps) and forms four
// partial products in the multiplier. After reset a clearing pass over all
// MAX_SNAPSHOTS*(DEGREE_CAP+1)*(DEGREE_CAP+2)/2 entries (8448 by default)
// runs before the first item is taken.
`default_nettype none
module snapshot_coefficient_interpolator_unit
    import sci_pkg::*;
#(
    parameter int MAX_SNAPSHOTS    = 16,
    parameter int DEGREE_CAP       = 31,
    parameter int WEIGHT_FRAC_BITS = 20
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_time, degree_index, order_index, load_cos, load_sin,
    // base_cos, base_sin
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // func
    input  wire logic [FUNC_W-1:0] s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // sum_cos, sum_sin
    output logic [OUT_W-1:0]       m_axis_tdata,
    // status
    output logic [STAT_W-1:0]      m_axis_tuser,
    input  wire logic              cfg_we,
    input  wire logic [DEG_W-1:0]  cfg_wdata
);

    ctl_cmd_t                 cmd;
    dp_stat_t                 st;
    status_t                  out_status;
    logic signed [COEF_W-1:0] out_cos, out_sin;

    sci_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    sci_datapath #(
        .MAX_SNAPSHOTS    (MAX_SNAPSHOTS),
        .DEGREE_CAP       (DEGREE_CAP),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_func     (func_t'(s_axis_tuser)),
        .in_time     (s_axis_tdata[31:0]),
        .in_degree   (s_axis_tdata[39:32]),
        .in_order    (s_axis_tdata[47:40]),
        .in_load_cos ($signed(s_axis_tdata[95:48])),
        .in_load_sin ($signed(s_axis_tdata[143:96])),
        .in_base_cos ($signed(s_axis_tdata[191:144])),
        .in_base_sin ($signed(s_axis_tdata[239:192])),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_status  (out_status),
        .out_cos     (out_cos),
        .out_sin     (out_sin)
    );

    // Result packing.
    assign m_axis_tdata = {out_sin, out_cos};
    assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
